@@ hdl/wsr_pkg.sv @@
// Shared types and constants for the WebSocket frame receiver.
`default_nettype none

package wsr_pkg;

  localparam int LENGTH_WIDTH_DEF = 64;

  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam int CONTROL_MAX_LEN = 125;

  localparam logic [7:0] PONG_HDR0 = 8'h8A;
  localparam logic [7:0] MASK_BIT  = 8'h80;

  localparam int PONG_BEATS = 6;
  localparam int BEAT_IDX_W = $clog2(PONG_BEATS);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_PONG    = 2'd1,
    KIND_CLOSED  = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Result produced by one input byte: a single beat, or a pong header burst.
  typedef struct packed {
    logic       has;
    logic       burst;
    kind_t      kind;
    logic [7:0] data;
  } event_t;

endpackage

`default_nettype wire

@@ hdl/wsr_parser.sv @@
// Frame header parser and payload unmasking, one byte per accepted beat.
`default_nettype none

module wsr_parser #(
  parameter int LENGTH_WIDTH = wsr_pkg::LENGTH_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  wire [7:0]            rx_byte,
  output wsr_pkg::event_t      ev
);

  wsr_pkg::phase_t           phase, phase_next;
  logic [3:0]                opcode, opcode_next;
  logic                      mask_present, mask_present_next;
  logic [7:0]                mask_key [4];
  logic [7:0]                mask_key_next [4];
  logic [1:0]                mask_pos, mask_pos_next;
  logic [LENGTH_WIDTH-1:0]   count, count_next;
  logic                      ovf, ovf_next;
  logic [2:0]                ext_idx, ext_idx_next;
  logic                      stopped, stopped_next;

  logic [LENGTH_WIDTH-1:0]   hdr_cnt;
  logic [LENGTH_WIDTH-1:0]   sat_cnt;
  logic [LENGTH_WIDTH-1:0]   shifted;
  logic                      len_go;
  logic                      hdr_go;

  assign shifted = {count[LENGTH_WIDTH-9:0], rx_byte};

  always_comb begin
    phase_next        = phase;
    opcode_next       = opcode;
    mask_present_next = mask_present;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    count_next        = count;
    ovf_next          = ovf;
    ext_idx_next      = ext_idx;
    stopped_next      = stopped;
    ev                = '0;
    hdr_cnt           = count;
    len_go            = 1'b0;
    hdr_go            = 1'b0;
    sat_cnt           = '0;

    if (stopped) begin
      ev.has  = 1'b1;
      ev.kind = (opcode == wsr_pkg::OP_CLOSE) ? wsr_pkg::KIND_CLOSED : wsr_pkg::KIND_ERROR;
    end else begin
      case (phase)
        wsr_pkg::PH_HDR1: begin
          mask_present_next = rx_byte[7];
          ovf_next          = 1'b0;
          if (rx_byte[6:0] == wsr_pkg::LEN_EXT16 || rx_byte[6:0] == wsr_pkg::LEN_EXT64) begin
            count_next   = '0;
            ext_idx_next = (rx_byte[6:0] == wsr_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
            phase_next   = wsr_pkg::PH_EXT;
          end else begin
            hdr_cnt = {{(LENGTH_WIDTH-7){1'b0}}, rx_byte[6:0]};
            len_go  = 1'b1;
          end
        end
        wsr_pkg::PH_EXT: begin
          // Bits pushed out of the top mean the length exceeds the counter.
          ovf_next = ovf | (|count[LENGTH_WIDTH-1 -: 8]);
          if (ext_idx == 3'd0) begin
            hdr_cnt = shifted;
            len_go  = 1'b1;
          end else begin
            count_next   = shifted;
            ext_idx_next = ext_idx - 3'd1;
          end
        end
        wsr_pkg::PH_MASK: begin
          mask_key_next[~ext_idx[1:0]] = rx_byte;
          if (ext_idx == 3'd0) begin
            hdr_go = 1'b1;
          end else begin
            ext_idx_next = ext_idx - 3'd1;
          end
        end
        wsr_pkg::PH_DATA: begin
          count_next = count - LENGTH_WIDTH'(1);
          if (count == LENGTH_WIDTH'(1)) begin
            phase_next = wsr_pkg::PH_HDR0;
          end
          if (opcode == wsr_pkg::OP_PING) begin
            ev.has  = 1'b1;
            ev.kind = wsr_pkg::KIND_PONG;
            ev.data = rx_byte;
          end else if (opcode != wsr_pkg::OP_PONG) begin
            ev.has  = 1'b1;
            ev.kind = wsr_pkg::KIND_PAYLOAD;
            if (mask_present) begin
              ev.data       = rx_byte ^ mask_key[mask_pos];
              mask_pos_next = mask_pos + 2'd1;
            end else begin
              ev.data = rx_byte;
            end
          end
        end
        default: begin
          opcode_next = rx_byte[3:0];
          phase_next  = wsr_pkg::PH_HDR1;
        end
      endcase

      if (len_go) begin
        count_next = hdr_cnt;
        if (mask_present_next) begin
          phase_next    = wsr_pkg::PH_MASK;
          ext_idx_next  = 3'd3;
          mask_pos_next = 2'd0;
        end else begin
          hdr_go = 1'b1;
        end
      end

      if (hdr_go) begin
        sat_cnt    = ovf_next ? '1 : hdr_cnt;
        count_next = sat_cnt;
        if (opcode == wsr_pkg::OP_CLOSE ||
            (opcode[3] && sat_cnt > LENGTH_WIDTH'(wsr_pkg::CONTROL_MAX_LEN))) begin
          stopped_next = 1'b1;
          ev.has       = 1'b1;
          ev.kind      = (opcode == wsr_pkg::OP_CLOSE) ? wsr_pkg::KIND_CLOSED
                                                       : wsr_pkg::KIND_ERROR;
        end else begin
          phase_next = (sat_cnt != '0) ? wsr_pkg::PH_DATA : wsr_pkg::PH_HDR0;
          if (opcode == wsr_pkg::OP_PING) begin
            ev.has   = 1'b1;
            ev.burst = 1'b1;
            ev.kind  = wsr_pkg::KIND_PONG;
            ev.data  = wsr_pkg::MASK_BIT | {1'b0, sat_cnt[6:0]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wsr_pkg::PH_HDR0;
      opcode       <= '0;
      mask_present <= 1'b0;
      mask_key     <= '{default: '0};
      mask_pos     <= '0;
      count        <= '0;
      ovf          <= 1'b0;
      ext_idx      <= '0;
      stopped      <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      opcode       <= opcode_next;
      mask_present <= mask_present_next;
      mask_key     <= mask_key_next;
      mask_pos     <= mask_pos_next;
      count        <= count_next;
      ovf          <= ovf_next;
      ext_idx      <= ext_idx_next;
      stopped      <= stopped_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wsr_emitter.sv @@
// Result register that sends single beats and expands pong header bursts.
`default_nettype none

module wsr_emitter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  wire wsr_pkg::event_t ev,
  output logic                busy,
  output logic                res_valid,
  input  wire                 res_stall,
  output logic [1:0]          kind,
  output logic [7:0]          data,
  output logic                last
);

  localparam logic [wsr_pkg::BEAT_IDX_W-1:0] LAST_BEAT =
    wsr_pkg::BEAT_IDX_W'(wsr_pkg::PONG_BEATS - 1);

  logic [wsr_pkg::BEAT_IDX_W-1:0] beat;
  logic [7:0]                    len_byte;
  logic                          take;

  assign take = res_valid && !res_stall;
  // Holding a beat that will not leave this cycle, or more beats of a burst.
  assign busy = res_valid && !(take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      beat      <= '0;
    end else if (take && !last) begin
      beat <= beat + wsr_pkg::BEAT_IDX_W'(1);
      data <= (beat == '0) ? len_byte : 8'h00;
      last <= (beat + wsr_pkg::BEAT_IDX_W'(1) == LAST_BEAT);
    end else if (load) begin
      res_valid <= 1'b1;
      beat      <= '0;
      kind      <= ev.kind;
      len_byte  <= ev.data;
      data      <= ev.burst ? wsr_pkg::PONG_HDR0 : ev.data;
      last      <= !ev.burst;
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/websocket_frame_receiver.sv @@
// Top level of the WebSocket frame receiver.
//
// Input channel: rx_byte with rx_valid / rx_stall, one received byte a beat.
// Result channel: kind, data, last with res_valid / res_stall.
// Each byte is parsed in the cycle it is accepted and its first result sits
// in the result register on the next cycle. Throughput is one byte per cycle
// while rx_stall is low. A byte that yields no result is always taken; a
// byte that yields a result waits only while the result register holds a
// beat that is not leaving this cycle.
// A ping header's last byte yields six pong header beats, sent one a cycle
// while res_stall is low; a byte that yields a result waits while they drain.
// A stalled result holds its value; bytes with results back up behind it.
// After a close frame or a protocol error every byte yields one status beat.
// Reset (rst, synchronous) returns the parser to waiting for a frame header
// and empties the result register.
`default_nettype none

module websocket_frame_receiver #(
  parameter int LENGTH_WIDTH = wsr_pkg::LENGTH_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        rx_valid,
  output logic       rx_stall,
  input  wire  [7:0] rx_byte,
  output logic       res_valid,
  input  wire        res_stall,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic       last
);

  wsr_pkg::event_t ev;
  logic            busy;
  logic            accept;

  assign rx_stall = busy && ev.has;
  assign accept   = rx_valid && !rx_stall;

  wsr_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .ev      (ev)
  );

  wsr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && ev.has),
    .ev        (ev),
    .busy      (busy),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .kind      (kind),
    .data      (data),
    .last      (last)
  );

endmodule

`default_nettype wire
